// ===== design/qwvs_pkg.sv =====
// ----------------------------------------------------------------------------
// qwvs_pkg
// Types and constants shared by the vertex skinning unit.
// ----------------------------------------------------------------------------
package qwvs_pkg;

   localparam logic [1:0] MODE_JOINT  = 2'd0;
   localparam logic [1:0] MODE_WEIGHT = 2'd1;
   localparam logic [1:0] MODE_VERTEX = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [11:0]        index;
      logic [7:0]         joint_id;
      logic [15:0]        bias;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic [4:0]         weight_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] final_x;
      logic signed [31:0] final_y;
      logic signed [31:0] final_z;
      logic [1:0]         status;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [1:0]         op;      // MODE_* or a status-only reply
      logic               err;
      logic [11:0]        index;
      logic [4:0]         count;
      logic [7:0]         joint_id;
      logic [15:0]        bias;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [47:0]        quat;
   } cmd_type;

endpackage

// ===== design/quaternion_weighted_vertex_skinning_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_weighted_vertex_skinning_unit
// Joint and weight stores with quaternion skinning of vertices.
//
//  channel  ports                          direction
//  request  start, busy, req_data          in
//  result   rsp_strobe, rsp_data           out
//
// A load joint subtracts the three squared terms and then takes the root in
// sixteen steps before its result; other loads and rejected requests go
// straight to the back end. A vertex takes four store reads and nineteen
// steps per weight through the one shared multiplier of the back end.
// The front holds one request while the back end is busy. Reset is
// synchronous and clears control only; stores are undefined until written.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module quaternion_weighted_vertex_skinning_unit #(
   parameter int JOINTS        = 256,
   parameter int WEIGHTS       = 4096,
   parameter int MAX_INFLUENCE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qwvs_pkg::req_type req_data,
   output logic              rsp_strobe,
   output qwvs_pkg::rsp_type rsp_data
);
   import qwvs_pkg::*;

   logic    cmd_valid, cmd_taken, fbusy;
   cmd_type cmd;
   logic [15:0] wq;

   qwvs_front #(.JOINTS(JOINTS), .WEIGHTS(WEIGHTS), .MAX_INFLUENCE(MAX_INFLUENCE)) u_front (
      .clock, .reset, .start, .busy(fbusy), .req(req_data),
      .cmd_valid, .cmd, .cmd_w(wq), .cmd_taken);

   qwvs_back #(.JOINTS(JOINTS), .WEIGHTS(WEIGHTS)) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_w(wq), .cmd_taken,
      .rsp_strobe, .rsp(rsp_data));

   assign busy = fbusy;
endmodule

// ===== design/qwvs_ram.sv =====
// ----------------------------------------------------------------------------
// qwvs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module qwvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/qwvs_front.sv =====
// ----------------------------------------------------------------------------
// qwvs_front
// Accepts requests, range checks them, computes the quaternion w of joint
// loads by an iterative square root and queues a command for the back end.
// ----------------------------------------------------------------------------
module qwvs_front #(
   parameter int JOINTS        = 256,
   parameter int WEIGHTS       = 4096,
   parameter int MAX_INFLUENCE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qwvs_pkg::req_type req,
   output logic              cmd_valid,
   output qwvs_pkg::cmd_type cmd,
   output logic [15:0]       cmd_w,
   input  logic              cmd_taken
);
   import qwvs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SQRT = 2'd1;
   localparam logic [1:0] S_OUT  = 2'd2;

   logic [1:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] bit_ff, bit_in;
   logic [1:0]  sq_ff, sq_in;
   logic signed [33:0] rad;
   logic signed [31:0] sqr;
   logic signed [15:0] qsel;
   logic        bad;
   logic [16:0] span;

   assign busy      = (state_ff != S_IDLE);
   assign cmd_valid = (state_ff == S_OUT);
   assign cmd       = cmd_ff;
   assign cmd_w     = 16'(32'd0 - root_ff);

   always_comb begin
      unique case (sq_ff)
         2'd0:    qsel = cmd_ff.quat[15:0];
         2'd1:    qsel = cmd_ff.quat[31:16];
         default: qsel = cmd_ff.quat[47:32];
      endcase
      sqr  = qsel * qsel;
      span = 17'(req.index) + 17'(req.weight_count);
      unique case (req.mode)
         MODE_JOINT:  bad = (32'(req.index) >= JOINTS);
         MODE_WEIGHT: bad = (32'(req.index) >= WEIGHTS) || (32'(req.joint_id) >= JOINTS);
         MODE_VERTEX: bad = (32'(req.weight_count) > MAX_INFLUENCE) || (32'(span) > WEIGHTS);
         default:     bad = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      sq_in    = sq_ff;
      rad      = $signed({2'b0, rem_ff}) - 34'(sqr);
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd_in.op       = req.mode;
            cmd_in.err      = bad;
            cmd_in.index    = req.index;
            cmd_in.count    = req.weight_count;
            cmd_in.joint_id = req.joint_id;
            cmd_in.bias     = req.bias;
            cmd_in.pos_x    = req.pos_x;
            cmd_in.pos_y    = req.pos_y;
            cmd_in.pos_z    = req.pos_z;
            cmd_in.quat     = {req.quat_z, req.quat_y, req.quat_x};
            rem_in          = 32'h4000_0000;
            sq_in           = 2'd0;
            root_in         = '0;
            bit_in          = 32'h4000_0000;
            state_in        = (req.mode == MODE_JOINT && !bad) ? S_SQRT : S_OUT;
         end
         S_SQRT: begin
            if (sq_ff != 2'd3) begin
               // subtract the squared terms one by one
               if (rad < 0) begin
                  rem_in = '0;
                  sq_in  = 2'd3;
                  bit_in = '0;
               end else begin
                  rem_in = rad[31:0];
                  sq_in  = sq_ff + 2'd1;
               end
            end else if (bit_ff != 0) begin
               if (rem_ff >= root_ff + bit_ff) begin
                  rem_in  = rem_ff - (root_ff + bit_ff);
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: if (cmd_taken) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
      cmd_ff  <= cmd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      sq_ff   <= sq_in;
   end
endmodule

// ===== design/qwvs_back.sv =====
// ----------------------------------------------------------------------------
// qwvs_back
// Executes queued commands: writes joint and weight stores and accumulates
// skinned vertex positions a weight at a time through a shared multiplier.
// ----------------------------------------------------------------------------
module qwvs_back #(
   parameter int JOINTS  = 256,
   parameter int WEIGHTS = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  qwvs_pkg::cmd_type cmd,
   input  logic [15:0]       cmd_w,
   output logic              cmd_taken,
   output logic              rsp_strobe,
   output qwvs_pkg::rsp_type rsp
);
   import qwvs_pkg::*;

   localparam int JW = $clog2(JOINTS);
   localparam int WW = $clog2(WEIGHTS);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDW  = 4'd1;
   localparam logic [3:0] S_WAW  = 4'd2;
   localparam logic [3:0] S_RDJ  = 4'd3;
   localparam logic [3:0] S_WAJ  = 4'd4;
   localparam logic [3:0] S_MUL  = 4'd5;
   localparam logic [3:0] S_DONE = 4'd6;

   logic [3:0] state_ff, state_in;
   logic [4:0] left_ff, left_in;
   logic [11:0] ptr_ff, ptr_in;
   logic [4:0] step_ff, step_in;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] acc_in [3];
   logic signed [63:0] u_ff [3];
   logic signed [63:0] u_in [3];
   logic signed [63:0] uu_ff [3];
   logic signed [63:0] uu_in [3];
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] tmp_ff, tmp_in;
   logic       strobe_ff, strobe_in;
   rsp_type    rsp_ff, rsp_in;

   // weight and joint store ports
   logic          w_we;
   logic [WW-1:0] w_wa, w_ra;
   logic [119:0]  w_rd;
   logic          j_we;
   logic [JW-1:0] j_wa, j_ra;
   logic [159:0]  j_rd;

   assign w_we = cmd_valid && state_ff == S_IDLE && cmd.op == MODE_WEIGHT && !cmd.err;
   assign w_wa = WW'(cmd.index);
   assign j_we = cmd_valid && state_ff == S_IDLE && cmd.op == MODE_JOINT && !cmd.err;
   assign j_wa = JW'(cmd.index);
   assign w_ra = WW'(ptr_ff);
   assign j_ra = JW'(w_rd[23:16]);

   qwvs_ram #(.WIDTH(120), .DEPTH(WEIGHTS)) u_wram (
      .clock, .wr_en(w_we), .wr_addr(w_wa),
      .wr_data({cmd.pos_z, cmd.pos_y, cmd.pos_x, cmd.joint_id, cmd.bias}),
      .rd_addr(w_ra), .rd_data(w_rd));

   qwvs_ram #(.WIDTH(160), .DEPTH(JOINTS)) u_jram (
      .clock, .wr_en(j_we), .wr_addr(j_wa),
      .wr_data({cmd.pos_z, cmd.pos_y, cmd.pos_x, cmd_w, cmd.quat}),
      .rd_addr(j_ra), .rd_data(j_rd));

   logic [119:0] wl_ff, wl_in;
   logic [159:0] jl_ff, jl_in;
   logic signed [63:0] v [3];
   logic signed [63:0] p [3];
   logic signed [15:0] qx, qy, qz, qw;
   logic signed [16:0] ma;
   logic signed [39:0] mb;
   logic signed [63:0] mres;

   assign cmd_taken  = cmd_valid && state_ff == S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   always_comb begin
      v[0] = 64'(signed'(wl_ff[55:24]));
      v[1] = 64'(signed'(wl_ff[87:56]));
      v[2] = 64'(signed'(wl_ff[119:88]));
      p[0] = 64'(signed'(jl_ff[95:64]));
      p[1] = 64'(signed'(jl_ff[127:96]));
      p[2] = 64'(signed'(jl_ff[159:128]));
      qx = jl_ff[15:0];
      qy = jl_ff[31:16];
      qz = jl_ff[47:32];
      qw = jl_ff[63:48];
   end

   // one multiply per cycle: operand A is a 17-bit coefficient, B at most 40 bits
   always_comb begin
      ma = '0;
      mb = '0;
      unique case (step_ff)
         5'd0:  begin ma = 17'(qy); mb = 40'(v[2]); end
         5'd1:  begin ma = 17'(qz); mb = 40'(v[1]); end
         5'd2:  begin ma = 17'(qz); mb = 40'(v[0]); end
         5'd3:  begin ma = 17'(qx); mb = 40'(v[2]); end
         5'd4:  begin ma = 17'(qx); mb = 40'(v[1]); end
         5'd5:  begin ma = 17'(qy); mb = 40'(v[0]); end
         5'd6:  begin ma = 17'(qz); mb = 40'(u_ff[1]); end
         5'd7:  begin ma = 17'(qy); mb = 40'(u_ff[2]); end
         5'd8:  begin ma = 17'(qz); mb = 40'(u_ff[0]); end
         5'd9:  begin ma = 17'(qx); mb = 40'(u_ff[2]); end
         5'd10: begin ma = 17'(qx); mb = 40'(u_ff[1]); end
         5'd11: begin ma = 17'(qy); mb = 40'(u_ff[0]); end
         5'd12: begin ma = 17'(qw); mb = 40'(u_ff[0]); end
         5'd13: begin ma = 17'(qw); mb = 40'(u_ff[1]); end
         5'd14: begin ma = 17'(qw); mb = 40'(u_ff[2]); end
         5'd15: begin ma = {1'b0, wl_ff[15:0]}; mb = 40'(uu_ff[0]); end
         5'd16: begin ma = {1'b0, wl_ff[15:0]}; mb = 40'(uu_ff[1]); end
         5'd17: begin ma = {1'b0, wl_ff[15:0]}; mb = 40'(uu_ff[2]); end
         default: ;
      endcase
      mres = ma * mb;
   end

   always_comb begin
      state_in  = state_ff;
      left_in   = left_ff;
      ptr_in    = ptr_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      u_in      = u_ff;
      uu_in     = uu_ff;
      prod_in   = mres;
      tmp_in    = tmp_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wl_in     = wl_ff;
      jl_in     = jl_ff;
      unique case (state_ff)
         S_IDLE: if (cmd_valid) begin
            ptr_in  = cmd.index;
            left_in = cmd.count;
            for (int k = 0; k < 3; k++) acc_in[k] = '0;
            if (cmd.op == MODE_VERTEX && !cmd.err && cmd.count != 0) state_in = S_RDW;
            else begin
               strobe_in     = 1'b1;
               rsp_in        = '0;
               rsp_in.status = cmd.err ? ST_RANGE : ST_OK;
            end
         end
         S_RDW: state_in = S_WAW;
         S_WAW: begin wl_in = w_rd; state_in = S_RDJ; end
         S_RDJ: state_in = S_WAJ;
         S_WAJ: begin jl_in = j_rd; step_in = '0; state_in = S_MUL; end
         S_MUL: begin
            // prod_ff holds the product issued on the previous step
            step_in = step_ff + 5'd1;
            unique case (step_ff)
               5'd1, 5'd3, 5'd5: tmp_in = prod_ff;
               5'd2:  u_in[0]  = (tmp_ff - prod_ff) >>> 15;
               5'd4:  u_in[1]  = (tmp_ff - prod_ff) >>> 15;
               5'd6:  u_in[2]  = (tmp_ff - prod_ff) >>> 15;
               5'd7, 5'd9, 5'd11: tmp_in = prod_ff;
               5'd8:  uu_in[0] = (prod_ff - tmp_ff) >>> 15;
               5'd10: uu_in[1] = (tmp_ff - prod_ff) >>> 15;
               5'd12: uu_in[2] = (tmp_ff - prod_ff) >>> 15;
               5'd13: uu_in[0] = p[0] + v[0] + 2 * ((prod_ff >>> 15) + uu_ff[0]);
               5'd14: uu_in[1] = p[1] + v[1] + 2 * ((prod_ff >>> 15) + uu_ff[1]);
               5'd15: uu_in[2] = p[2] + v[2] + 2 * ((prod_ff >>> 15) + uu_ff[2]);
               5'd16: acc_in[0] = acc_ff[0] + (prod_ff >>> 15);
               5'd17: acc_in[1] = acc_ff[1] + (prod_ff >>> 15);
               5'd18: begin
                  acc_in[2] = acc_ff[2] + (prod_ff >>> 15);
                  left_in   = left_ff - 5'd1;
                  ptr_in    = ptr_ff + 12'd1;
                  state_in  = (left_ff == 5'd1) ? S_DONE : S_RDW;
               end
               default: ;
            endcase
         end
         S_DONE: begin
            strobe_in     = 1'b1;
            rsp_in.status = ST_OK;
            for (int k = 0; k < 3; k++) begin
               if (acc_ff[k] > 64'sh7FFF_FFFF) begin
                  acc_in[k] = 64'sh7FFF_FFFF; rsp_in.status = ST_SAT;
               end else if (acc_ff[k] < -64'sh8000_0000) begin
                  acc_in[k] = -64'sh8000_0000; rsp_in.status = ST_SAT;
               end else acc_in[k] = acc_ff[k];
            end
            rsp_in.final_x = acc_in[0][31:0];
            rsp_in.final_y = acc_in[1][31:0];
            rsp_in.final_z = acc_in[2][31:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      left_ff <= left_in;
      ptr_ff  <= ptr_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      u_ff    <= u_in;
      uu_ff   <= uu_in;
      prod_ff <= prod_in;
      tmp_ff  <= tmp_in;
      rsp_ff  <= rsp_in;
      wl_ff   <= wl_in;
      jl_ff   <= jl_in;
   end

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_IDLE || state_ff == S_DONE)) else $error("strobe");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_taken |-> state_ff == S_IDLE) else $error("take");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe || $past(cmd_valid)) else $error("strobe run");
endmodule

// ===== test/qwvs_checker.sv =====
// ----------------------------------------------------------------------------
// qwvs_checker
// Watches the request and result channels of the skinning unit, keeps its
// own copy of the joint and weight stores, predicts every result and
// compares each strobed result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qwvs_checker #(
   parameter int JOINTS        = 256,
   parameter int WEIGHTS       = 4096,
   parameter int MAX_INFLUENCE = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  qwvs_pkg::req_type req,
   input  logic              rsp_strobe,
   input  qwvs_pkg::rsp_type rsp,
   output int                fails,
   output int                pending
);
   import qwvs_pkg::*;

   logic signed [31:0] jpos_x [JOINTS];
   logic signed [31:0] jpos_y [JOINTS];
   logic signed [31:0] jpos_z [JOINTS];
   logic signed [15:0] jq_x [JOINTS];
   logic signed [15:0] jq_y [JOINTS];
   logic signed [15:0] jq_z [JOINTS];
   logic signed [15:0] jq_w [JOINTS];
   logic [7:0]         wjoint [WEIGHTS];
   logic [15:0]        wbias [WEIGHTS];
   logic signed [31:0] woff_x [WEIGHTS];
   logic signed [31:0] woff_y [WEIGHTS];
   logic signed [31:0] woff_z [WEIGHTS];

   rsp_type expected_rsps[$];

   function automatic longint int_sqrt(longint n);
      longint root;
      longint b;
      root = 0;
      b = 64'sd1 << 62;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >>> 1) + b;
         end else begin
            root = root >>> 1;
         end
         b = b >>> 2;
      end
      return root;
   endfunction

   function automatic void rotate_offset(input int j, input longint v0, input longint v1,
                                         input longint v2, output longint r0,
                                         output longint r1, output longint r2);
      longint qx, qy, qz, qw, u0, u1, u2, t0, t1, t2;
      qx = jq_x[j];
      qy = jq_y[j];
      qz = jq_z[j];
      qw = jq_w[j];
      u0 = (qy * v2 - qz * v1) >>> 15;
      u1 = (qz * v0 - qx * v2) >>> 15;
      u2 = (qx * v1 - qy * v0) >>> 15;
      t0 = (qy * u2 - qz * u1) >>> 15;
      t1 = (qz * u0 - qx * u2) >>> 15;
      t2 = (qx * u1 - qy * u0) >>> 15;
      r0 = v0 + 2 * (((u0 * qw) >>> 15) + t0);
      r1 = v1 + 2 * (((u1 * qw) >>> 15) + t1);
      r2 = v2 + 2 * (((u2 * qw) >>> 15) + t2);
   endfunction

   function automatic longint clip32(longint v, inout bit clipped);
      if (v > 64'sd2147483647) begin
         clipped = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic rsp_type skin_request(req_type r);
      rsp_type res;
      longint radicand, qx, qy, qz, b, r0, r1, r2;
      longint sum[3];
      int cnt, idx, j;
      bit clipped;
      res = '0;
      sum = '{0, 0, 0};
      clipped = 0;
      cnt = r.weight_count;
      idx = r.index;
      case (r.mode)
         MODE_JOINT: begin
            if (idx >= JOINTS) begin
               res.status = ST_RANGE;
            end else begin
               qx = r.quat_x;
               qy = r.quat_y;
               qz = r.quat_z;
               radicand = (64'sd1 << 30) - qx * qx - qy * qy - qz * qz;
               jq_w[idx] = (radicand < 0) ? 16'sd0 : 16'(-int_sqrt(radicand));
               jpos_x[idx] = r.pos_x;
               jpos_y[idx] = r.pos_y;
               jpos_z[idx] = r.pos_z;
               jq_x[idx] = r.quat_x;
               jq_y[idx] = r.quat_y;
               jq_z[idx] = r.quat_z;
            end
         end
         MODE_WEIGHT: begin
            if (idx >= WEIGHTS || r.joint_id >= JOINTS) begin
               res.status = ST_RANGE;
            end else begin
               wjoint[idx] = r.joint_id;
               wbias[idx] = r.bias;
               woff_x[idx] = r.pos_x;
               woff_y[idx] = r.pos_y;
               woff_z[idx] = r.pos_z;
            end
         end
         MODE_VERTEX: begin
            if (cnt > MAX_INFLUENCE || idx + cnt > WEIGHTS) begin
               res.status = ST_RANGE;
            end else begin
               for (int i = idx; i < idx + cnt; i++) begin
                  j = wjoint[i];
                  b = wbias[i];
                  rotate_offset(j, woff_x[i], woff_y[i], woff_z[i], r0, r1, r2);
                  sum[0] += ((jpos_x[j] + r0) * b) >>> 15;
                  sum[1] += ((jpos_y[j] + r1) * b) >>> 15;
                  sum[2] += ((jpos_z[j] + r2) * b) >>> 15;
               end
               res.final_x = 32'(clip32(sum[0], clipped));
               res.final_y = 32'(clip32(sum[1], clipped));
               res.final_z = 32'(clip32(sum[2], clipped));
               if (clipped) res.status = ST_SAT;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         expected_rsps.delete();
         fails   <= 0;
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result %h", rsp);
               errs++;
            end else begin
               want = expected_rsps.pop_back();
               if (rsp.final_x !== want.final_x) begin
                  $error("final_x expected %h actual %h", want.final_x, rsp.final_x);
                  errs++;
               end
               if (rsp.final_y !== want.final_y) begin
                  $error("final_y expected %h actual %h", want.final_y, rsp.final_y);
                  errs++;
               end
               if (rsp.final_z !== want.final_z) begin
                  $error("final_z expected %h actual %h", want.final_z, rsp.final_z);
                  errs++;
               end
               if (rsp.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp.status);
                  errs++;
               end
            end
         end
         if (start && !busy) expected_rsps.push_front(skin_request(req));
         fails   <= fails + errs;
         pending <= expected_rsps.size();
      end
   end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression for the vertex skinning unit. Directed requests cover store
// extremes, every mode and the range, saturation and degenerate quaternion
// cases; random requests then load joints and weights and skin vertices over
// runs whose slots and joints have all been loaded, mixed with noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import qwvs_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_strobe;
   rsp_type rsp;
   int      fails;
   int      pending;
   int      idle_cycles;
   int      sent;
   int      vertices;
   bit      joint_loaded [256];
   bit      weight_loaded [4096];
   int      loaded_joints[$];

   quaternion_weighted_vertex_skinning_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp)
   );

   qwvs_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .fails(fails), .pending(pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("quaternion_weighted_vertex_skinning_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] any_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 131072)) - 65536);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_req();
      logic [223:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   task automatic issue(req_type r);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      sent++;
      if (r.mode == MODE_JOINT && r.index < 256 && !joint_loaded[r.index]) begin
         joint_loaded[r.index] = 1;
         loaded_joints.push_front(r.index);
      end
      if (r.mode == MODE_WEIGHT) weight_loaded[r.index] = 1;
      if (r.mode == MODE_VERTEX) vertices++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic req_type joint_load(int idx);
      req_type r;
      r = random_req();
      r.mode = MODE_JOINT;
      r.index = 12'(idx);
      r.pos_x = any_word();
      r.pos_y = any_word();
      r.pos_z = any_word();
      if ($urandom_range(0, 2) == 0) begin
         r.quat_x = 16'(int'($urandom_range(0, 36000)) - 18000);
         r.quat_y = 16'(int'($urandom_range(0, 36000)) - 18000);
         r.quat_z = 16'(int'($urandom_range(0, 36000)) - 18000);
      end
      return r;
   endfunction

   function automatic req_type weight_load(int idx);
      req_type r;
      r = random_req();
      r.mode = MODE_WEIGHT;
      r.index = 12'(idx);
      r.joint_id = 8'(loaded_joints[$urandom_range(0, loaded_joints.size() - 1)]);
      if ($urandom_range(0, 3) != 0) r.bias = 16'($urandom_range(0, 32768));
      r.pos_x = any_word();
      r.pos_y = any_word();
      r.pos_z = any_word();
      return r;
   endfunction

   function automatic req_type vertex_req(int idx, int cnt);
      req_type r;
      r = random_req();
      r.mode = MODE_VERTEX;
      r.index = 12'(idx);
      r.weight_count = 5'(cnt);
      return r;
   endfunction

   initial begin
      req_type r;
      int s, cnt, pick;
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      sent = 0;
      vertices = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      r = joint_load(0);
      r.quat_x = '0; r.quat_y = '0; r.quat_z = '0;
      issue(r);
      r = joint_load(255);
      r.pos_x = 32'h7fffffff; r.pos_y = 32'h7fffffff; r.pos_z = 32'h80000000;
      r.quat_x = 16'h8000; r.quat_y = 16'h8000; r.quat_z = 16'h8000;
      issue(r);
      r = joint_load(4095);
      issue(r);
      r = weight_load(0);
      r.joint_id = '0; r.bias = 16'd32768;
      issue(r);
      r = weight_load(1);
      r.joint_id = 8'd255; r.bias = 16'd0;
      issue(r);
      r = weight_load(2);
      r.joint_id = 8'd255; r.bias = 16'hffff;
      r.pos_x = 32'h7fffffff; r.pos_y = 32'h7fffffff; r.pos_z = 32'h80000000;
      issue(r);
      r = weight_load(4095);
      r.joint_id = 8'd255; r.bias = 16'hffff;
      r.pos_x = 32'h80000000; r.pos_y = 32'h80000000; r.pos_z = 32'h80000000;
      issue(r);
      issue(vertex_req(0, 1));
      issue(vertex_req(2, 1));
      issue(vertex_req(0, 3));
      issue(vertex_req(4095, 1));
      issue(vertex_req(5, 0));
      issue(vertex_req(0, 17));
      issue(vertex_req(4095, 31));
      issue(vertex_req(4090, 16));
      r = vertex_req(0, 1);
      r.mode = MODE_UNUSED;
      issue(r);
      drain();

      while (sent < 1150) begin
         pick = $urandom_range(0, 99);
         if (sent > 600 && sent < 610) drain();
         if (pick < 10) begin
            issue(joint_load($urandom_range(0, 7) == 0 ? $urandom_range(256, 4095)
                                                       : $urandom_range(0, 255)));
         end else if (pick < 18) begin
            issue(weight_load($urandom_range(0, 4095)));
         end else if (pick < 26) begin
            r = vertex_req($urandom_range(0, 4095), $urandom_range(0, 31));
            if ($urandom_range(0, 1) == 0) r.mode = MODE_UNUSED;
            else if (r.weight_count <= 16 && r.index + r.weight_count <= 4096)
               r.weight_count = 5'($urandom_range(17, 31));
            issue(r);
         end else begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, 63);
            cnt = $urandom_range(0, 16);
            if (s + cnt > 4096) cnt = 4096 - s;
            for (int i = s; i < s + cnt; i++)
               if (!weight_loaded[i] || $urandom_range(0, 9) == 0) issue(weight_load(i));
            issue(vertex_req(s, cnt));
         end
      end

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d requests, %0d vertex requests, %0d joints loaded",
               sent, vertices, loaded_joints.size());
      if (fails == 0) begin
         $display("quaternion_weighted_vertex_skinning_unit regression: pass");
      end else begin
         $display("quaternion_weighted_vertex_skinning_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/qwvs_pkg.sv
design/qwvs_ram.sv
design/qwvs_front.sv
design/qwvs_back.sv
design/quaternion_weighted_vertex_skinning_unit.sv
test/qwvs_checker.sv
test/tb.sv
